>>> hw/rtl/y86e_pkg.sv
`timescale 1ns / 1ps
// Shared opcode, function and condition codes and flag types for the execute stage.
package y86e_pkg;

  localparam logic [3:0] OP_RRMOV = 4'd2;
  localparam logic [3:0] OP_IRMOV = 4'd3;
  localparam logic [3:0] OP_RMMOV = 4'd4;
  localparam logic [3:0] OP_MRMOV = 4'd5;
  localparam logic [3:0] OP_ALU   = 4'd6;
  localparam logic [3:0] OP_JXX   = 4'd7;
  localparam logic [3:0] OP_CALL  = 4'd8;
  localparam logic [3:0] OP_RET   = 4'd9;
  localparam logic [3:0] OP_PUSH  = 4'd10;
  localparam logic [3:0] OP_POP   = 4'd11;
  localparam logic [3:0] OP_IADD  = 4'd12;

  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_XOR = 4'd3;

  localparam logic [3:0] COND_ALWAYS = 4'd0;
  localparam logic [3:0] COND_LE     = 4'd1;
  localparam logic [3:0] COND_L      = 4'd2;
  localparam logic [3:0] COND_E      = 4'd3;
  localparam logic [3:0] COND_NE     = 4'd4;
  localparam logic [3:0] COND_GE     = 4'd5;
  localparam logic [3:0] COND_G      = 4'd6;

  localparam logic [3:0] NO_REG    = 4'd15;
  localparam logic [1:0] STATUS_OK = 2'd0;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  typedef struct packed {
    logic   set;
    flags_t flags;
  } cc_upd_t;

endpackage

>>> hw/rtl/y86e_alu.sv
`timescale 1ns / 1ps
// Operand selection, ALU and condition code computation.
module y86e_alu import y86e_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic [3:0]            opcode_i,
  input  logic [3:0]            function_code_i,
  input  logic [DATA_WIDTH-1:0] value_a_i,
  input  logic [DATA_WIDTH-1:0] value_b_i,
  input  logic [DATA_WIDTH-1:0] value_c_i,
  input  logic                  exc_i,
  output logic [DATA_WIDTH-1:0] result_o,
  output cc_upd_t               cc_o
);

  localparam logic [DATA_WIDTH-1:0] MinusEight = {{(DATA_WIDTH-4){1'b1}}, 4'b1000};
  localparam logic [DATA_WIDTH-1:0] PlusEight  = DATA_WIDTH'(8);

  logic [DATA_WIDTH-1:0] a_w;
  logic [DATA_WIDTH-1:0] b_w;
  logic [DATA_WIDTH-1:0] r_w;
  logic [3:0]            fn_w;
  logic                  fn_ok_w;
  logic                  of_w;
  logic                  a_top_w;
  logic                  b_top_w;
  logic                  r_top_w;

  always_comb begin
    unique case (opcode_i)
      OP_RRMOV, OP_ALU:                     a_w = value_a_i;
      OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_IADD: a_w = value_c_i;
      OP_CALL, OP_PUSH:                     a_w = MinusEight;
      OP_RET, OP_POP:                       a_w = PlusEight;
      default:                              a_w = '0;
    endcase
  end

  always_comb begin
    unique case (opcode_i)
      OP_RMMOV, OP_MRMOV, OP_ALU, OP_CALL,
      OP_PUSH, OP_RET, OP_POP, OP_IADD: b_w = value_b_i;
      default:                         b_w = '0;
    endcase
  end

  assign fn_w = (opcode_i == OP_ALU) ? function_code_i : ALU_ADD;

  always_comb begin
    fn_ok_w = 1'b1;
    unique case (fn_w)
      ALU_ADD: r_w = a_w + b_w;
      ALU_SUB: r_w = b_w - a_w;
      ALU_AND: r_w = a_w & b_w;
      ALU_XOR: r_w = a_w ^ b_w;
      default: begin
        r_w     = '0;
        fn_ok_w = 1'b0;
      end
    endcase
  end

  assign a_top_w = a_w[DATA_WIDTH-1];
  assign b_top_w = b_w[DATA_WIDTH-1];
  assign r_top_w = r_w[DATA_WIDTH-1];

  always_comb begin
    unique case (fn_w)
      ALU_ADD: of_w = (a_top_w == b_top_w) && (r_top_w != a_top_w);
      ALU_SUB: of_w = (a_top_w != b_top_w) && (r_top_w != b_top_w);
      default: of_w = 1'b0;
    endcase
  end

  assign result_o     = r_w;
  assign cc_o.set     = ((opcode_i == OP_ALU) || (opcode_i == OP_IADD)) && !exc_i && fn_ok_w;
  assign cc_o.flags.zf = (r_w == '0);
  assign cc_o.flags.sf = r_top_w;
  assign cc_o.flags.of = of_w;

endmodule

>>> hw/rtl/y86e_cond.sv
`timescale 1ns / 1ps
// Jump and conditional move condition evaluation against the held flags.
module y86e_cond import y86e_pkg::*; (
  input  logic [3:0] opcode_i,
  input  logic [3:0] function_code_i,
  input  flags_t     flags_i,
  output logic       taken_o
);

  logic lt_w;
  logic met_w;

  assign lt_w = flags_i.sf ^ flags_i.of;

  always_comb begin
    unique case (function_code_i)
      COND_ALWAYS: met_w = 1'b1;
      COND_LE:     met_w = lt_w || flags_i.zf;
      COND_L:      met_w = lt_w;
      COND_E:      met_w = flags_i.zf;
      COND_NE:     met_w = !flags_i.zf;
      COND_GE:     met_w = !lt_w;
      COND_G:      met_w = !lt_w && !flags_i.zf;
      default:     met_w = 1'b0;
    endcase
  end

  assign taken_o = ((opcode_i == OP_JXX) || (opcode_i == OP_RRMOV)) && met_w;

endmodule

>>> hw/rtl/y86_pipeline_execute_stage.sv
`timescale 1ns / 1ps
// Top level of the Y86-64 execute stage: input register, ALU, flags, result register.
//
// One instruction per clock while the output is not stalled: a beat accepted on the input
// is held in an input register, passes the operand select, ALU and condition logic, and
// lands in the result register. The ZF/SF/OF flags are written as a valid ALU or IADD
// instruction leaves the input register with no memory or writeback exception, so the
// condition of each instruction sees the flags left by the one before it. in_stall_o
// rises only when both registers are full and the output is stalled.
module y86_pipeline_execute_stage import y86e_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            stage_status_i,
  input  logic [3:0]            opcode_i,
  input  logic [3:0]            function_code_i,
  input  logic [DATA_WIDTH-1:0] value_a_i,
  input  logic [DATA_WIDTH-1:0] value_b_i,
  input  logic [DATA_WIDTH-1:0] value_c_i,
  input  logic [3:0]            dest_e_i,
  input  logic [3:0]            dest_m_i,
  input  logic [1:0]            mem_stage_status_i,
  input  logic [1:0]            wb_stage_status_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            out_status_o,
  output logic [3:0]            out_opcode_o,
  output logic [DATA_WIDTH-1:0] out_value_a_o,
  output logic [3:0]            out_dest_m_o,
  output logic [3:0]            out_dest_e_o,
  output logic                  condition_taken_o,
  output logic [DATA_WIDTH-1:0] alu_result_o,
  output logic                  memory_bubble_o
);

  logic                  in_valid_q;
  logic [1:0]            st_q;
  logic [3:0]            op_q;
  logic [3:0]            fn_q;
  logic [DATA_WIDTH-1:0] va_q;
  logic [DATA_WIDTH-1:0] vb_q;
  logic [DATA_WIDTH-1:0] vc_q;
  logic [3:0]            de_q;
  logic [3:0]            dm_q;
  logic [1:0]            ms_q;
  logic [1:0]            ws_q;

  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [3:0]            out_opcode_q;
  logic [DATA_WIDTH-1:0] out_value_a_q;
  logic [3:0]            out_dest_m_q;
  logic [3:0]            out_dest_e_q;
  logic                  cond_q;
  logic [DATA_WIDTH-1:0] result_q;
  logic                  bubble_q;

  flags_t                flags_q;
  flags_t                flags_d;

  logic                  move_w;
  logic                  take_w;
  logic                  exc_w;
  logic                  cond_w;
  logic [DATA_WIDTH-1:0] result_w;
  logic [3:0]            dest_e_w;
  cc_upd_t               cc_w;

  assign move_w     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !move_w;
  assign take_w     = in_valid_i && !in_stall_o;
  assign exc_w      = (ms_q != STATUS_OK) || (ws_q != STATUS_OK);

  y86e_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .opcode_i       (op_q),
    .function_code_i(fn_q),
    .value_a_i      (va_q),
    .value_b_i      (vb_q),
    .value_c_i      (vc_q),
    .exc_i          (exc_w),
    .result_o       (result_w),
    .cc_o           (cc_w)
  );

  y86e_cond u_cond (
    .opcode_i       (op_q),
    .function_code_i(fn_q),
    .flags_i        (flags_q),
    .taken_o        (cond_w)
  );

  assign dest_e_w = ((op_q == OP_RRMOV) && !cond_w) ? NO_REG : de_q;
  assign flags_d  = (move_w && cc_w.set) ? cc_w.flags : flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      flags_q <= flags_d;
      if (take_w) begin
        in_valid_q <= 1'b1;
      end else if (move_w) begin
        in_valid_q <= 1'b0;
      end
      if (move_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_w) begin
      st_q <= stage_status_i;
      op_q <= opcode_i;
      fn_q <= function_code_i;
      va_q <= value_a_i;
      vb_q <= value_b_i;
      vc_q <= value_c_i;
      de_q <= dest_e_i;
      dm_q <= dest_m_i;
      ms_q <= mem_stage_status_i;
      ws_q <= wb_stage_status_i;
    end
    if (move_w) begin
      out_status_q  <= st_q;
      out_opcode_q  <= op_q;
      out_value_a_q <= va_q;
      out_dest_m_q  <= dm_q;
      out_dest_e_q  <= dest_e_w;
      cond_q        <= cond_w;
      result_q      <= result_w;
      bubble_q      <= exc_w;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_opcode_o      = out_opcode_q;
  assign out_value_a_o     = out_value_a_q;
  assign out_dest_m_o      = out_dest_m_q;
  assign out_dest_e_o      = out_dest_e_q;
  assign condition_taken_o = cond_q;
  assign alu_result_o      = result_q;
  assign memory_bubble_o   = bubble_q;

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move_w |=> (flags_q == $past(flags_q)))
    else $error("flags changed without an instruction leaving the input register");

  a_flags_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move_w && exc_w) |=> (flags_q == $past(flags_q)))
    else $error("flags changed under a memory or writeback exception");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while a register slot was free");

  a_cmov_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_opcode_q == OP_RRMOV) && !cond_q) |-> (out_dest_e_q == NO_REG))
    else $error("failed cmov kept its destination");

  a_cond_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cond_q) |-> ((out_opcode_q == OP_RRMOV) || (out_opcode_q == OP_JXX)))
    else $error("condition taken for an opcode without a condition");

endmodule
